### rtl/nlpm_pkg.sv
// Package for the NFA longest prefix match block: request codes, register
// indexes, fixed field widths and the table command bundle.
// No dependencies; compiled first.
package nlpm_pkg;

   localparam int SET_W       = 16;
   localparam int STATE_IDX_W = 4;
   localparam int SYMBOL_W    = 8;
   localparam int LEN_OUT_W   = 16;

   typedef enum logic [1:0] {
      KIND_ROW_WRITE   = 2'd0,
      KIND_ALPHA_WRITE = 2'd1,
      KIND_START       = 2'd2,
      KIND_FEED        = 2'd3
   } req_kind_type;

   typedef enum logic [0:0] {
      CSR_START_SET  = 1'b0,
      CSR_ACCEPT_SET = 1'b1
   } csr_idx_type;

   // command from the request side to the table memory
   typedef struct packed {
      logic                   wr_row;
      logic                   wr_alpha;
      logic                   rd;
      logic [STATE_IDX_W-1:0] state_index;
      logic [SET_W-1:0]       next_set;
      logic                   allowed;
   } tbl_cmd_type;

endpackage

### rtl/nlpm_if.sv
// Channel interfaces: request, result and register write.
// Depends on nlpm_pkg.
interface nlpm_req_if;
   logic                                valid;
   logic                                ready;
   nlpm_pkg::req_kind_type              req_type;
   logic [nlpm_pkg::STATE_IDX_W-1:0]    state_index;
   logic [nlpm_pkg::SYMBOL_W-1:0]       symbol;
   logic [nlpm_pkg::SET_W-1:0]          next_set;
   logic                                allowed;

   modport source (output valid, req_type, state_index, symbol, next_set, allowed,
                   input ready);
   modport sink   (input valid, req_type, state_index, symbol, next_set, allowed,
                   output ready);
endinterface

interface nlpm_rsp_if;
   logic                                valid;
   logic                                ready;
   logic                                matched;
   logic [nlpm_pkg::LEN_OUT_W-1:0]      match_length;
   logic                                scanning;
   logic [nlpm_pkg::SET_W-1:0]          active_states;

   modport source (output valid, matched, match_length, scanning, active_states,
                   input ready);
   modport sink   (input valid, matched, match_length, scanning, active_states,
                   output ready);
endinterface

interface nlpm_csr_if;
   logic                                valid;
   logic                                ready;
   nlpm_pkg::csr_idx_type               reg_index;
   logic [nlpm_pkg::SET_W-1:0]          wr_data;

   modport source (output valid, reg_index, wr_data, input ready);
   modport sink   (input valid, reg_index, wr_data, output ready);
endinterface

### rtl/nfa_longest_prefix_match_top.sv
// Top level of the NFA longest prefix match block: request decode, scan
// state update and result register. Depends on nlpm_pkg, nlpm_if.sv and
// nlpm_table_mem.
//
//  Channel | Direction | Handshake     | Carries
//  --------+-----------+---------------+------------------------------------------
//  req     | in        | valid/ready   | req_type, state_index, symbol, next_set,
//          |           |               | allowed
//  rsp     | out       | valid/ready   | matched, match_length, scanning,
//          |           |               | active_states
//  csr     | in        | valid/ready   | reg_index, wr_data (start_set, accept_set)
//
// One request per cycle sustained once the sweep is done and while results are
// drained. Accepting a request loads the table read register and the scan stage;
// the scan update is then loaded into the result register, which offers the result.
// After reset the table memory is swept clear, one byte row per cycle; req.ready
// stays low during the sweep. Register writes are always taken. A stalled result
// holds the scan stage, which holds req.ready low.
module nfa_longest_prefix_match_top #(
   parameter int NUM_STATES   = 16,
   parameter int NUM_SYMBOLS  = 256,
   parameter int LENGTH_WIDTH = 16
) (
   input logic       clock,
   input logic       reset,
   nlpm_req_if.sink  req_chan,
   nlpm_rsp_if.source rsp_chan,
   nlpm_csr_if.sink  csr_chan
);

   localparam int SYM_AW    = $clog2(NUM_SYMBOLS);
   localparam int ROW_W     = NUM_STATES * NUM_STATES + 1;
   localparam int ALPHA_BIT = NUM_STATES * NUM_STATES;

   // ---------------------------------------------------------------------
   // Configuration registers
   // ---------------------------------------------------------------------
   logic [nlpm_pkg::SET_W-1:0] start_ff, start_in;
   logic [nlpm_pkg::SET_W-1:0] accept_ff, accept_in;

   assign csr_chan.ready = 1'b1;

   always_comb begin
      start_in  = start_ff;
      accept_in = accept_ff;
      if (csr_chan.valid) begin
         unique case (csr_chan.reg_index)
            nlpm_pkg::CSR_START_SET:  start_in  = csr_chan.wr_data;
            nlpm_pkg::CSR_ACCEPT_SET: accept_in = csr_chan.wr_data;
            default: ;
         endcase
      end
   end

   // ---------------------------------------------------------------------
   // Request stage: decode and issue the memory access
   // ---------------------------------------------------------------------
   logic                  tbl_busy;
   logic                  req_accept;
   logic                  req_sym_ok;
   nlpm_pkg::tbl_cmd_type tbl_cmd;
   logic [ROW_W-1:0]      rd_row;

   logic                   s1_valid_ff, s1_valid_in;
   nlpm_pkg::req_kind_type s1_kind_ff;
   logic                   s1_sym_ok_ff;
   logic                   s1_move;

   logic rsp_valid_ff, rsp_valid_in;

   // scan stage advances when the result register is free or being drained
   assign s1_move         = s1_valid_ff && (!rsp_valid_ff || rsp_chan.ready);
   assign req_chan.ready  = !tbl_busy && (!s1_valid_ff || s1_move);
   assign req_accept      = req_chan.valid && req_chan.ready;
   assign req_sym_ok      = int'(req_chan.symbol) < NUM_SYMBOLS;

   always_comb begin
      tbl_cmd.wr_row      = req_accept && req_sym_ok &&
                            (req_chan.req_type == nlpm_pkg::KIND_ROW_WRITE);
      tbl_cmd.wr_alpha    = req_accept && req_sym_ok &&
                            (req_chan.req_type == nlpm_pkg::KIND_ALPHA_WRITE);
      tbl_cmd.rd          = req_accept && req_sym_ok &&
                            (req_chan.req_type == nlpm_pkg::KIND_FEED);
      tbl_cmd.state_index = req_chan.state_index;
      tbl_cmd.next_set    = req_chan.next_set;
      tbl_cmd.allowed     = req_chan.allowed;
   end

   // writes land at acceptance, so a feed taken next cycle already reads them
   nlpm_table_mem #(
      .NUM_STATES  (NUM_STATES),
      .NUM_SYMBOLS (NUM_SYMBOLS)
   ) u_table (
      .clock     (clock),
      .reset     (reset),
      .cmd       (tbl_cmd),
      .addr      (req_chan.symbol[SYM_AW-1:0]),
      .rd_row_ff (rd_row),
      .busy      (tbl_busy)
   );

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (req_accept) begin
         s1_valid_in = 1'b1;
      end else if (s1_move) begin
         s1_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
      if (req_accept) begin
         s1_kind_ff   <= req_chan.req_type;
         s1_sym_ok_ff <= req_sym_ok;
      end
   end

   // ---------------------------------------------------------------------
   // Scan stage: update the automaton state from the row just read
   // ---------------------------------------------------------------------
   logic [NUM_STATES-1:0]   active_ff, active_in;
   logic                    match_ff, match_in;
   logic [LENGTH_WIDTH-1:0] best_len_ff, best_len_in;
   logic [LENGTH_WIDTH-1:0] pos_ff, pos_in;
   logic                    halted_ff, halted_in;
   logic [NUM_STATES-1:0]   step_set;
   logic [NUM_STATES-1:0]   accept_mask;
   logic [NUM_STATES-1:0]   start_mask;

   assign accept_mask = NUM_STATES'(accept_ff);
   assign start_mask  = NUM_STATES'(start_ff);

   // union of the rows of all active states
   always_comb begin
      step_set = '0;
      for (int s = 0; s < NUM_STATES; s++) begin
         if (active_ff[s]) begin
            step_set = step_set | rd_row[s*NUM_STATES +: NUM_STATES];
         end
      end
   end

   always_comb begin
      active_in   = active_ff;
      match_in    = match_ff;
      best_len_in = best_len_ff;
      pos_in      = pos_ff;
      halted_in   = halted_ff;
      if (s1_move) begin
         unique case (s1_kind_ff)
            nlpm_pkg::KIND_ROW_WRITE,
            nlpm_pkg::KIND_ALPHA_WRITE: ;
            nlpm_pkg::KIND_START: begin
               active_in   = start_mask;
               match_in    = |(start_mask & accept_mask);
               best_len_in = '0;
               pos_in      = '0;
               halted_in   = 1'b0;
            end
            nlpm_pkg::KIND_FEED: begin
               if (!halted_ff) begin
                  if (!s1_sym_ok_ff || !rd_row[ALPHA_BIT]) begin
                     halted_in = 1'b1;
                  end else begin
                     active_in = step_set;
                     if (pos_ff != {LENGTH_WIDTH{1'b1}}) begin
                        pos_in = pos_ff + 1'b1;
                     end
                     if (|(step_set & accept_mask)) begin
                        match_in    = 1'b1;
                        best_len_in = pos_in;
                     end
                  end
               end
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         start_ff    <= nlpm_pkg::SET_W'(1);
         accept_ff   <= '0;
         active_ff   <= '0;
         match_ff    <= 1'b0;
         best_len_ff <= '0;
         pos_ff      <= '0;
         halted_ff   <= 1'b1;
      end else begin
         start_ff    <= start_in;
         accept_ff   <= accept_in;
         active_ff   <= active_in;
         match_ff    <= match_in;
         best_len_ff <= best_len_in;
         pos_ff      <= pos_in;
         halted_ff   <= halted_in;
      end
   end

   // ---------------------------------------------------------------------
   // Result register
   // ---------------------------------------------------------------------
   logic                           rsp_matched_ff;
   logic [nlpm_pkg::LEN_OUT_W-1:0] rsp_len_ff;
   logic                           rsp_scanning_ff;
   logic [nlpm_pkg::SET_W-1:0]     rsp_active_ff;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (s1_move) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      if (s1_move) begin
         rsp_matched_ff  <= match_in;
         rsp_len_ff      <= nlpm_pkg::LEN_OUT_W'(best_len_in);
         rsp_scanning_ff <= !halted_in;
         rsp_active_ff   <= nlpm_pkg::SET_W'(active_in);
      end
   end

   assign rsp_chan.valid         = rsp_valid_ff;
   assign rsp_chan.matched       = rsp_matched_ff;
   assign rsp_chan.match_length  = rsp_len_ff;
   assign rsp_chan.scanning      = rsp_scanning_ff;
   assign rsp_chan.active_states = rsp_active_ff;

   // ---------------------------------------------------------------------
   // Assertions
   // ---------------------------------------------------------------------
   // no request may slip in while the memory sweep is running
   a_no_accept_in_sweep: assert property (@(posedge clock) disable iff (reset)
      tbl_busy |-> !req_accept)
      else $error("request taken during table sweep");

   // a recorded match can never be longer than the bytes consumed
   a_best_within_pos: assert property (@(posedge clock) disable iff (reset)
      best_len_ff <= pos_ff)
      else $error("best length exceeds position");

   // without a match the recorded length stays zero
   a_no_match_no_len: assert property (@(posedge clock) disable iff (reset)
      !match_ff |-> (best_len_ff == '0))
      else $error("length recorded without a match");

   // a feed while halted leaves the scan state untouched
   a_halted_feed_holds: assert property (@(posedge clock) disable iff (reset)
      (s1_move && halted_ff && (s1_kind_ff == nlpm_pkg::KIND_FEED)) |=>
         ($stable(active_ff) && $stable(pos_ff) && halted_ff))
      else $error("halted feed changed scan state");

endmodule

### rtl/nlpm_table_mem.sv
// Transition and alphabet memory: one word per byte holding every state's
// successor row plus the alphabet bit. Clears itself after reset.
// Depends on nlpm_pkg.
module nlpm_table_mem #(
   parameter int NUM_STATES  = 16,
   parameter int NUM_SYMBOLS = 256,
   localparam int SYM_AW     = $clog2(NUM_SYMBOLS),
   localparam int ROW_W      = NUM_STATES * NUM_STATES + 1
) (
   input  logic                  clock,
   input  logic                  reset,
   input  nlpm_pkg::tbl_cmd_type cmd,
   input  logic [SYM_AW-1:0]     addr,
   output logic [ROW_W-1:0]      rd_row_ff,
   output logic                  busy
);

   localparam int ALPHA_BIT = NUM_STATES * NUM_STATES;

   logic [ROW_W-1:0]  mem [NUM_SYMBOLS];
   logic              clr_busy_ff, clr_busy_in;
   logic [SYM_AW-1:0] clr_addr_ff, clr_addr_in;

   assign busy = clr_busy_ff;

   always_comb begin
      clr_busy_in = clr_busy_ff;
      clr_addr_in = clr_addr_ff;
      if (clr_busy_ff) begin
         clr_addr_in = clr_addr_ff + 1'b1;
         if (clr_addr_ff == SYM_AW'(NUM_SYMBOLS - 1)) begin
            clr_busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_busy_ff <= 1'b1;
         clr_addr_ff <= '0;
      end else begin
         clr_busy_ff <= clr_busy_in;
         clr_addr_ff <= clr_addr_in;
      end
   end

   // one slice per source state; a state index out of range matches no slice
   always_ff @(posedge clock) begin
      if (clr_busy_ff) begin
         mem[clr_addr_ff] <= '0;
      end else begin
         if (cmd.wr_row) begin
            for (int s = 0; s < NUM_STATES; s++) begin
               if (int'(cmd.state_index) == s) begin
                  mem[addr][s*NUM_STATES +: NUM_STATES] <= NUM_STATES'(cmd.next_set);
               end
            end
         end
         if (cmd.wr_alpha) begin
            mem[addr][ALPHA_BIT] <= cmd.allowed;
         end
      end
      if (cmd.rd) begin
         rd_row_ff <= mem[addr];
      end
   end

endmodule
